/* hdl/tfr_pkg.sv */
// Shared types and codes for the triangle fill rasterizer.
// No dependencies; imported by the front, back and top-level modules.
package tfr_pkg;

    // Item classes decided by the front end
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_LOAD   = 2'd0;
    localparam t_kind KIND_REFUSE = 2'd1;
    localparam t_kind KIND_TICK   = 2'd2;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status STS_OK         = 2'd0;
    localparam t_status STS_NO_DISPLAY = 2'd1;
    localparam t_status STS_IDLE_TICK  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_HEIGHT  = 2'd1;
    localparam logic [1:0] CFG_DISPLAY = 2'd2;

    localparam int SCREEN_BITS = 11;
    localparam int INDEX_BITS  = 22;
    localparam int COLOR_BITS  = 32;

    // Head of the command queue as seen by the back end
    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_q_ctl;

    // Vertex that follows / precedes vertex i in a, b, c order
    function automatic logic [1:0] f_next(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd1;
            2'd1:    r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] f_prev(input logic [1:0] i);
        logic [1:0] r;
        case (i)
            2'd0:    r = 2'd2;
            2'd1:    r = 2'd0;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

endpackage

/* hdl/tfr_front.sv */
// Front end: accepts input beats, classifies them and holds them in a
// two-entry command queue. Depends on tfr_pkg.
module tfr_front
    import tfr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cmd,
    input  logic [6*COORD_BITS-1:0]   i_vtx,
    input  logic [COLOR_BITS-1:0]     i_fill_color,
    input  logic                      i_disp_en,
    output t_q_ctl                    o_q,
    output logic [6*COORD_BITS-1:0]   o_q_vtx,
    output logic [COLOR_BITS-1:0]     o_q_color,
    input  logic                      i_pop
);

    t_kind                    r_kind  [2];
    logic [6*COORD_BITS-1:0]  r_vtx   [2];
    logic [COLOR_BITS-1:0]    r_color [2];
    logic                     r_head;
    logic                     r_tail;
    logic [1:0]               r_count;
    logic                     push;
    t_kind                    kind_in;

    assign o_in_ready = (r_count != 2'd2);
    assign push       = i_in_valid && o_in_ready;

    // Classify: refuse loads while the display is off
    always_comb begin
        if (i_cmd) begin
            kind_in = KIND_TICK;
        end else if (i_disp_en) begin
            kind_in = KIND_LOAD;
        end else begin
            kind_in = KIND_REFUSE;
        end
    end

    // Store the beat at the tail
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_kind[r_tail]  <= kind_in;
            r_vtx[r_tail]   <= i_vtx;
            r_color[r_tail] <= i_fill_color;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 1'b0;
            r_tail  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_tail <= ~r_tail;
            end
            if (i_pop) begin
                r_head <= ~r_head;
            end
            if (push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_q.valid = (r_count != 2'd0);
    assign o_q.kind  = r_kind[r_head];
    assign o_q_vtx   = r_vtx[r_head];
    assign o_q_color = r_color[r_head];

endmodule

/* hdl/tfr_back.sv */
// Back end: triangle set-up through a shared multiplier, incremental edge
// scan over the bounding box, and the result register. Depends on tfr_pkg.
module tfr_back
    import tfr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_q_ctl                       i_q,
    input  logic [6*COORD_BITS-1:0]      i_q_vtx,
    input  logic [COLOR_BITS-1:0]        i_q_color,
    output logic                         o_pop,
    input  logic [SCREEN_BITS-1:0]       i_width,
    input  logic [SCREEN_BITS-1:0]       i_height,
    input  logic                         i_disp_en,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_write_enable,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [INDEX_BITS-1:0]        o_pixel_index,
    output logic [COLOR_BITS-1:0]        o_pixel_color,
    output logic                         o_done_res,
    output t_status                      o_status
);

    localparam int P  = COORD_BITS;
    localparam int W  = 2 * P + 2;       // edge value width
    localparam int MW = P + 11;          // index sum width

    // Triangle state
    logic signed [P-1:0]  r_vx [3];
    logic signed [P-1:0]  r_vy [3];
    logic signed [P:0]    r_kx [3];
    logic signed [P:0]    r_ky [3];
    logic signed [W-1:0]  r_e    [3];
    logic signed [W-1:0]  r_ecol [3];
    logic [W-1:0]         r_area;
    logic [COLOR_BITS-1:0] r_color;
    logic signed [P-1:0]  r_minx;
    logic signed [P-1:0]  r_miny;
    logic signed [P-1:0]  r_maxx;
    logic signed [P-1:0]  r_maxy;
    logic signed [P-1:0]  r_x;
    logic signed [P-1:0]  r_y;
    logic                 r_busy;

    // Set-up sequencer
    logic                 r_seq_run;
    logic [1:0]           r_grp;
    logic [1:0]           r_term;
    logic signed [2*P:0]  r_prod;
    logic                 r_prod_vld;
    logic [1:0]           r_prod_grp;
    logic [1:0]           r_prod_term;
    logic signed [W-1:0]  r_acc;

    // Result register
    logic                  r_out_vld;
    logic                  r_we;
    logic signed [P-1:0]   r_px;
    logic signed [P-1:0]   r_py;
    logic [INDEX_BITS-1:0] r_idx;
    logic [COLOR_BITS-1:0] r_pcolor;
    logic                  r_done;
    t_status               r_status;

    logic                  n_we;
    logic signed [P-1:0]   n_px;
    logic signed [P-1:0]   n_py;
    logic [INDEX_BITS-1:0] n_idx;
    logic [COLOR_BITS-1:0] n_pcolor;
    logic                  n_done;
    t_status               n_status;

    logic signed [P-1:0]  vx_in [3];
    logic signed [P-1:0]  vy_in [3];
    logic signed [P-1:0]  minx_in, maxx_in, miny_in, maxy_in;
    logic signed [P-1:0]  sx [3];
    logic signed [P-1:0]  sy [3];
    logic signed [P-1:0]  mul_a;
    logic signed [P:0]    mul_b;
    logic signed [W-1:0]  acc_n;
    logic [W-1:0]         abs_acc;
    logic [W-1:0]         abs_e [3];
    logic [W:0]           sum_abs;
    logic                 covered;
    logic                 onscreen;
    logic                 last;
    logic signed [P+11:0] x_ext, y_ext, w_ext, h_ext;
    logic [P+9:0]         row_base;
    logic [MW-1:0]        idx_sum;
    logic [MW+INDEX_BITS-1:0] idx_ext;
    logic                 do_tick;
    logic                 do_load;

    assign o_pop   = i_q.valid && !r_seq_run && !r_prod_vld && (!r_out_vld || i_out_ready);
    assign do_load = o_pop && (i_q.kind == KIND_LOAD);
    assign do_tick = o_pop && (i_q.kind == KIND_TICK) && r_busy;

    // Unpack incoming vertices and form the bounding box
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            vx_in[j] = i_q_vtx[(2*j)*P +: P];
            vy_in[j] = i_q_vtx[(2*j+1)*P +: P];
        end
        minx_in = (vx_in[0] < vx_in[1]) ? vx_in[0] : vx_in[1];
        minx_in = (minx_in < vx_in[2]) ? minx_in : vx_in[2];
        maxx_in = (vx_in[0] > vx_in[1]) ? vx_in[0] : vx_in[1];
        maxx_in = (maxx_in > vx_in[2]) ? maxx_in : vx_in[2];
        miny_in = (vy_in[0] < vy_in[1]) ? vy_in[0] : vy_in[1];
        miny_in = (miny_in < vy_in[2]) ? miny_in : vy_in[2];
        maxy_in = (vy_in[0] > vy_in[1]) ? vy_in[0] : vy_in[1];
        maxy_in = (maxy_in > vy_in[2]) ? maxy_in : vy_in[2];
    end

    // Pick the multiplier operands: vertex grp swapped for the box corner
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            sx[j] = (r_grp == 2'(j)) ? r_minx : r_vx[j];
            sy[j] = (r_grp == 2'(j)) ? r_miny : r_vy[j];
        end
        case (r_term)
            2'd1: begin
                mul_a = sx[1];
                mul_b = {sy[2][P-1], sy[2]} - {sy[0][P-1], sy[0]};
            end
            2'd2: begin
                mul_a = sx[2];
                mul_b = {sy[0][P-1], sy[0]} - {sy[1][P-1], sy[1]};
            end
            default: begin
                mul_a = sx[0];
                mul_b = {sy[1][P-1], sy[1]} - {sy[2][P-1], sy[2]};
            end
        endcase
    end

    // Accumulate three products per group
    always_comb begin
        acc_n   = ((r_prod_term == 2'd0) ? '0 : r_acc) + {r_prod[2*P], r_prod};
        abs_acc = acc_n[W-1] ? W'(-acc_n) : W'(acc_n);
    end

    // Coverage, screen and index terms for the current point
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            abs_e[j] = r_e[j][W-1] ? W'(-r_e[j]) : W'(r_e[j]);
        end
        sum_abs  = {1'b0, abs_e[0]} + {1'b0, abs_e[1]} + {1'b0, abs_e[2]};
        covered  = (sum_abs == {1'b0, r_area});
        x_ext    = {{12{r_x[P-1]}}, r_x};
        y_ext    = {{12{r_y[P-1]}}, r_y};
        w_ext    = {{(P+1){1'b0}}, i_width};
        h_ext    = {{(P+1){1'b0}}, i_height};
        onscreen = !r_x[P-1] && !r_y[P-1] && (x_ext < w_ext) && (y_ext < h_ext);
        last     = (r_x == r_maxx) && (r_y == r_maxy);
        row_base = r_y[P-2:0] * i_width;
        idx_sum  = {1'b0, row_base} + {12'b0, r_x[P-2:0]};
        idx_ext  = {{INDEX_BITS{1'b0}}, idx_sum};
    end

    // Build the next result
    always_comb begin
        n_we     = 1'b0;
        n_px     = '0;
        n_py     = '0;
        n_idx    = '0;
        n_pcolor = '0;
        n_done   = 1'b0;
        n_status = STS_OK;
        unique case (i_q.kind)
            KIND_LOAD: begin
                n_status = STS_OK;
            end
            KIND_REFUSE: begin
                n_status = STS_NO_DISPLAY;
            end
            KIND_TICK: begin
                if (!r_busy) begin
                    n_status = STS_IDLE_TICK;
                end else begin
                    n_px   = r_x;
                    n_py   = r_y;
                    n_done = last;
                    if (covered && onscreen && i_disp_en) begin
                        n_we     = 1'b1;
                        n_idx    = idx_ext[INDEX_BITS-1:0];
                        n_pcolor = r_color;
                    end
                end
            end
            default: begin
                n_status = STS_OK;
            end
        endcase
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_pop) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_we     <= n_we;
            r_px     <= n_px;
            r_py     <= n_py;
            r_idx    <= n_idx;
            r_pcolor <= n_pcolor;
            r_done   <= n_done;
            r_status <= n_status;
        end
    end

    // Sequencer and scan control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_seq_run  <= 1'b0;
            r_prod_vld <= 1'b0;
            r_grp      <= 2'd0;
            r_term     <= 2'd0;
        end else begin
            r_prod_vld <= r_seq_run;
            if (do_load) begin
                r_busy    <= 1'b1;
                r_seq_run <= 1'b1;
                r_grp     <= 2'd0;
                r_term    <= 2'd0;
            end else if (r_seq_run) begin
                if (r_term == 2'd2) begin
                    r_term <= 2'd0;
                    if (r_grp == 2'd3) begin
                        r_seq_run <= 1'b0;
                    end else begin
                        r_grp <= r_grp + 2'd1;
                    end
                end else begin
                    r_term <= r_term + 2'd1;
                end
            end
            if (do_tick && (r_y >= r_maxy) && (r_x >= r_maxx)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Triangle set-up, products and edge stepping
    always_ff @(posedge i_clk) begin
        r_prod      <= mul_a * mul_b;
        r_prod_grp  <= r_grp;
        r_prod_term <= r_term;
        if (do_load) begin
            for (int j = 0; j < 3; j++) begin
                r_vx[j] <= vx_in[j];
                r_vy[j] <= vy_in[j];
                r_kx[j] <= {vy_in[f_next(2'(j))][P-1], vy_in[f_next(2'(j))]}
                         - {vy_in[f_prev(2'(j))][P-1], vy_in[f_prev(2'(j))]};
                r_ky[j] <= {vx_in[f_prev(2'(j))][P-1], vx_in[f_prev(2'(j))]}
                         - {vx_in[f_next(2'(j))][P-1], vx_in[f_next(2'(j))]};
            end
            r_color <= i_q_color;
            r_minx  <= minx_in;
            r_maxx  <= maxx_in;
            r_miny  <= miny_in;
            r_maxy  <= maxy_in;
            r_x     <= minx_in;
            r_y     <= miny_in;
        end else if (r_prod_vld) begin
            r_acc <= acc_n;
            if (r_prod_term == 2'd2) begin
                if (r_prod_grp == 2'd3) begin
                    r_area <= abs_acc;
                end else begin
                    r_e[r_prod_grp]    <= acc_n;
                    r_ecol[r_prod_grp] <= acc_n;
                end
            end
        end else if (do_tick) begin
            if (r_y >= r_maxy) begin
                if (r_x < r_maxx) begin
                    r_x <= r_x + P'(1);
                    r_y <= r_miny;
                    for (int j = 0; j < 3; j++) begin
                        r_ecol[j] <= r_ecol[j] + {{(W-P-1){r_kx[j][P]}}, r_kx[j]};
                        r_e[j]    <= r_ecol[j] + {{(W-P-1){r_kx[j][P]}}, r_kx[j]};
                    end
                end
            end else begin
                r_y <= r_y + P'(1);
                for (int j = 0; j < 3; j++) begin
                    r_e[j] <= r_e[j] + {{(W-P-1){r_ky[j][P]}}, r_ky[j]};
                end
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_write_enable = r_we;
    assign o_pixel_x      = r_px;
    assign o_pixel_y      = r_py;
    assign o_pixel_index  = r_idx;
    assign o_pixel_color  = r_pcolor;
    assign o_done_res     = r_done;
    assign o_status       = r_status;

endmodule

/* hdl/triangle_fill_rasterizer_unit.sv */
// A beat accepted into the queue is popped into the result register when
// the back end is free. Ticks sustain one beat per cycle while the output
// is not stalled; a load holds the back end while the one shared multiplier
// forms the three starting edge values and the twice-area, twelve products.
// Reset (synchronous, active low) empties the queue, ends any scan, and sets
// width 640, height 480, display off.
module triangle_fill_rasterizer_unit
    import tfr_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [SCREEN_BITS-1:0]       i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_cmd,
    input  logic signed [COORD_BITS-1:0] i_vertex_a_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_a_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_b_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_b_y,
    input  logic signed [COORD_BITS-1:0] i_vertex_c_x,
    input  logic signed [COORD_BITS-1:0] i_vertex_c_y,
    input  logic [COLOR_BITS-1:0]        i_fill_color,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_write_enable,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic [INDEX_BITS-1:0]        o_pixel_index,
    output logic [COLOR_BITS-1:0]        o_pixel_color,
    output logic                         o_done_res,
    output logic [1:0]                   o_status
);

    logic [SCREEN_BITS-1:0]   r_width;
    logic [SCREEN_BITS-1:0]   r_height;
    logic                     r_disp_en;
    t_q_ctl                   q_ctl;
    logic [6*COORD_BITS-1:0]  q_vtx;
    logic [COLOR_BITS-1:0]    q_color;
    logic                     pop;
    logic [6*COORD_BITS-1:0]  vtx_in;
    t_status                  status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= 11'd640;
            r_height  <= 11'd480;
            r_disp_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_WIDTH:   r_width   <= i_cfg_data;
                CFG_HEIGHT:  r_height  <= i_cfg_data;
                CFG_DISPLAY: r_disp_en <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign vtx_in = {i_vertex_c_y, i_vertex_c_x, i_vertex_b_y,
                     i_vertex_b_x, i_vertex_a_y, i_vertex_a_x};

    tfr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_vtx        (vtx_in),
        .i_fill_color (i_fill_color),
        .i_disp_en    (r_disp_en),
        .o_q          (q_ctl),
        .o_q_vtx      (q_vtx),
        .o_q_color    (q_color),
        .i_pop        (pop)
    );

    tfr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (q_ctl),
        .i_q_vtx        (q_vtx),
        .i_q_color      (q_color),
        .o_pop          (pop),
        .i_width        (r_width),
        .i_height       (r_height),
        .i_disp_en      (r_disp_en),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_write_enable (o_write_enable),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_color  (o_pixel_color),
        .o_done_res     (o_done_res),
        .o_status       (status)
    );

    assign o_status = status;

endmodule

/* bench/tb.sv */
// Testbench for triangle_fill_rasterizer_unit: directed and random load/tick beats under
// random input gaps and output stalls, each result checked against an in-bench coverage model.
// Depends on tfr_pkg (hdl/tfr_pkg.sv) and the top level hdl/triangle_fill_rasterizer_unit.sv.
module tb
    import tfr_pkg::*;
();

    localparam int CB            = 12;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASES        = 12;
    localparam int PHASE_BEATS   = 100;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic                  cmd;
        logic signed [CB-1:0]  ax;
        logic signed [CB-1:0]  ay;
        logic signed [CB-1:0]  bx;
        logic signed [CB-1:0]  by;
        logic signed [CB-1:0]  cx;
        logic signed [CB-1:0]  cy;
        logic [COLOR_BITS-1:0] color;
    } t_beat;

    typedef struct packed {
        logic                  we;
        logic signed [CB-1:0]  x;
        logic signed [CB-1:0]  y;
        logic [INDEX_BITS-1:0] index;
        logic [COLOR_BITS-1:0] color;
        logic                  done;
        t_status               status;
    } t_pixel;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_TOGGLE} t_rx_mode;

    // DUT side signals
    logic                   i_clk        = 1'b0;
    logic                   i_rst_n      = 1'b0;
    logic                   i_cfg_we     = 1'b0;
    logic [1:0]             i_cfg_index  = CFG_WIDTH;
    logic [SCREEN_BITS-1:0] i_cfg_data   = '0;
    logic                   i_in_valid   = 1'b0;
    logic                   o_in_ready;
    logic                   i_cmd        = CMD_LOAD;
    logic signed [CB-1:0]   i_vertex_a_x = '0;
    logic signed [CB-1:0]   i_vertex_a_y = '0;
    logic signed [CB-1:0]   i_vertex_b_x = '0;
    logic signed [CB-1:0]   i_vertex_b_y = '0;
    logic signed [CB-1:0]   i_vertex_c_x = '0;
    logic signed [CB-1:0]   i_vertex_c_y = '0;
    logic [COLOR_BITS-1:0]  i_fill_color = '0;
    logic                   o_out_valid;
    logic                   i_out_ready  = 1'b0;
    logic                   o_write_enable;
    logic signed [CB-1:0]   o_pixel_x;
    logic signed [CB-1:0]   o_pixel_y;
    logic [INDEX_BITS-1:0]  o_pixel_index;
    logic [COLOR_BITS-1:0]  o_pixel_color;
    logic                   o_done_res;
    logic [1:0]             o_status;

    triangle_fill_rasterizer_unit #(.COORD_BITS(CB)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_cmd          (i_cmd),
        .i_vertex_a_x   (i_vertex_a_x),
        .i_vertex_a_y   (i_vertex_a_y),
        .i_vertex_b_x   (i_vertex_b_x),
        .i_vertex_b_y   (i_vertex_b_y),
        .i_vertex_c_x   (i_vertex_c_x),
        .i_vertex_c_y   (i_vertex_c_y),
        .i_fill_color   (i_fill_color),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_write_enable (o_write_enable),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_index  (o_pixel_index),
        .o_pixel_color  (o_pixel_color),
        .o_done_res     (o_done_res),
        .o_status       (o_status)
    );

    always #5 i_clk = ~i_clk;

    // Hard stop for a hung handshake
    initial begin
        #20_000_000;
        $display("** triangle_fill_rasterizer_unit: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Coverage model: screen registers and scan state, reset values
    // ------------------------------------------------------------------
    logic [SCREEN_BITS-1:0] scr_w   = 11'd640;
    logic [SCREEN_BITS-1:0] scr_h   = 11'd480;
    logic                   disp_on = 1'b0;
    longint                 vtx[6]  = '{0, 0, 0, 0, 0, 0};
    logic [COLOR_BITS-1:0]  paint   = '0;
    longint                 area2   = 0;
    longint                 min_x   = 0;
    longint                 max_x   = 0;
    longint                 min_y   = 0;
    longint                 max_y   = 0;
    longint                 cur_x   = 0;
    longint                 cur_y   = 0;
    bit                     scanning = 1'b0;

    t_pixel pending_pixels[$];
    int     mismatches = 0;
    int     burst_left = 0;

    function automatic longint area_twice(input longint ax, input longint ay,
                                          input longint bx, input longint by,
                                          input longint cx, input longint cy);
        longint s;
        s = ax * (by - cy) + bx * (cy - ay) + cx * (ay - by);
        return (s < 0) ? -s : s;
    endfunction

    function automatic longint lo3(input longint a, input longint b, input longint c);
        longint m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic longint hi3(input longint a, input longint b, input longint c);
        longint m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    // Apply one beat to the model and return the pixel result it produces
    function automatic t_pixel rasterize_beat(input t_beat b);
        t_pixel r;
        longint x, y, a1, a2, a3, idx;
        bit     covered, visible, last;
        r = '0;
        if (b.cmd == CMD_LOAD) begin
            if (!disp_on) begin
                r.status = STS_NO_DISPLAY;
                return r;
            end
            vtx[0] = $signed(b.ax);
            vtx[1] = $signed(b.ay);
            vtx[2] = $signed(b.bx);
            vtx[3] = $signed(b.by);
            vtx[4] = $signed(b.cx);
            vtx[5] = $signed(b.cy);
            paint  = b.color;
            area2  = area_twice(vtx[0], vtx[1], vtx[2], vtx[3], vtx[4], vtx[5]);
            min_x  = lo3(vtx[0], vtx[2], vtx[4]);
            max_x  = hi3(vtx[0], vtx[2], vtx[4]);
            min_y  = lo3(vtx[1], vtx[3], vtx[5]);
            max_y  = hi3(vtx[1], vtx[3], vtx[5]);
            cur_x  = min_x;
            cur_y  = min_y;
            scanning = 1'b1;
            r.status = STS_OK;
            return r;
        end
        if (!scanning) begin
            r.status = STS_IDLE_TICK;
            return r;
        end
        x  = cur_x;
        y  = cur_y;
        a1 = area_twice(x, y, vtx[2], vtx[3], vtx[4], vtx[5]);
        a2 = area_twice(vtx[0], vtx[1], x, y, vtx[4], vtx[5]);
        a3 = area_twice(vtx[0], vtx[1], vtx[2], vtx[3], x, y);
        covered = (area2 == a1 + a2 + a3);
        visible = (x >= 0) && (y >= 0) && (x < longint'(scr_w)) && (y < longint'(scr_h));
        last    = (x == max_x) && (y == max_y);
        if (covered && visible && disp_on) begin
            idx     = y * longint'(scr_w) + x;
            r.we    = 1'b1;
            r.index = idx[INDEX_BITS-1:0];
            r.color = paint;
        end
        r.x      = x[CB-1:0];
        r.y      = y[CB-1:0];
        r.done   = last;
        r.status = STS_OK;
        // Advance: y inner, x outer
        if (y >= max_y) begin
            if (x >= max_x) begin
                scanning = 1'b0;
            end else begin
                cur_x = x + 1;
                cur_y = min_y;
            end
        end else begin
            cur_y = y + 1;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat construction
    // ------------------------------------------------------------------
    function automatic t_beat noise_beat();
        t_beat       b;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b   = raw[$bits(t_beat)-1:0];
        return b;
    endfunction

    function automatic t_beat tick_beat();
        t_beat b;
        b     = noise_beat();
        b.cmd = CMD_TICK;
        return b;
    endfunction

    function automatic t_beat load_beat(input int ax, input int ay, input int bx,
                                        input int by, input int cx, input int cy,
                                        input logic [COLOR_BITS-1:0] color);
        t_beat b;
        b.cmd   = CMD_LOAD;
        b.ax    = ax[CB-1:0];
        b.ay    = ay[CB-1:0];
        b.bx    = bx[CB-1:0];
        b.by    = by[CB-1:0];
        b.cx    = cx[CB-1:0];
        b.cy    = cy[CB-1:0];
        b.color = color;
        return b;
    endfunction

    // ------------------------------------------------------------------
    // Input side: bursts with random gaps
    // ------------------------------------------------------------------
    task automatic send_beat(input t_beat b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid   <= 1'b1;
        i_cmd        <= b.cmd;
        i_vertex_a_x <= b.ax;
        i_vertex_a_y <= b.ay;
        i_vertex_b_x <= b.bx;
        i_vertex_b_y <= b.by;
        i_vertex_c_x <= b.cx;
        i_vertex_c_y <= b.cy;
        i_fill_color <= b.color;
        // Hold the beat until it is taken
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_pixels.push_back(rasterize_beat(b));
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(tick_beat());
    endtask

    // Drop valid and wait until every expected pixel has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [SCREEN_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_WIDTH:   scr_w = data;
            CFG_HEIGHT:  scr_h = data;
            CFG_DISPLAY: disp_on = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Display enable with junk in the unused upper data bits
    task automatic write_display(input logic on);
        logic [SCREEN_BITS-1:0] d;
        d    = SCREEN_BITS'($urandom);
        d[0] = on;
        write_reg(CFG_DISPLAY, d);
    endtask

    task automatic program_screen(input int w, input int h, input logic on);
        drain();
        write_reg(CFG_WIDTH, w[SCREEN_BITS-1:0]);
        write_reg(CFG_HEIGHT, h[SCREEN_BITS-1:0]);
        write_display(on);
    endtask

    // Small triangle somewhere in the plane; reports the number of box points
    task automatic send_small_triangle(output int points);
        int    x0, y0, span, pick;
        t_beat b;
        span = ($urandom_range(0, 1) == 0) ? 3 : 7;
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
            x0 = $urandom_range(0, 4095) - 2048;
            y0 = $urandom_range(0, 4095) - 2048;
        end else if (pick == 1) begin
            x0 = $urandom_range(0, 2055) - 8;
            y0 = $urandom_range(0, 2055) - 8;
        end else begin
            x0 = $urandom_range(0, scr_w + 16) - 8;
            y0 = $urandom_range(0, scr_h + 16) - 8;
        end
        if (x0 > 2047 - span) x0 = 2047 - span;
        if (y0 > 2047 - span) y0 = 2047 - span;
        b = load_beat(x0 + $urandom_range(0, span), y0 + $urandom_range(0, span),
                      x0 + $urandom_range(0, span), y0 + $urandom_range(0, span),
                      x0 + $urandom_range(0, span), y0 + $urandom_range(0, span),
                      $urandom);
        points = int'((hi3(b.ax, b.bx, b.cx) - lo3(b.ax, b.bx, b.cx) + 1) *
                      (hi3(b.ay, b.by, b.cy) - lo3(b.ay, b.by, b.cy) + 1));
        send_beat(b);
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern plus a long hold on request
    // ------------------------------------------------------------------
    t_rx_mode rx_mode      = RX_OPEN;
    int       rx_mode_left = 0;
    int       hold_left    = 0;
    logic     hold_req     = 1'b0;
    logic     hold_seen    = 1'b0;

    always @(posedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      <= t_rx_mode'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(10, 200);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   i_out_ready <= 1'b1;
                RX_COIN:   i_out_ready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: i_out_ready <= ($urandom_range(0, 7) != 0);
                default:   i_out_ready <= ~i_out_ready;
            endcase
        end
    end

    // Compare each accepted result beat with the oldest expected pixel
    always @(posedge i_clk) begin : check_pixels
        t_pixel got;
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = {o_write_enable, o_pixel_x, o_pixel_y, o_pixel_index, o_pixel_color,
                   o_done_res, o_status};
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: we=%0b x=%0d y=%0d st=%0d",
                             $time, got.we, got.x, got.y, got.status);
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: pixel mismatch", $time);
                        $display("  exp we=%0b x=%0d y=%0d idx=%0d color=%h done=%0b st=%0d",
                                 want.we, want.x, want.y, want.index, want.color,
                                 want.done, want.status);
                        $display("  got we=%0b x=%0d y=%0d idx=%0d color=%h done=%0b st=%0d",
                                 got.we, got.x, got.y, got.index, got.color,
                                 got.done, got.status);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Idle tick and refused load out of reset, then reset screen size at its edges
    task automatic test_reset_defaults();
        send_beat(tick_beat());
        send_beat(load_beat(1, 2, 3, 4, 5, 6, 32'hDEAD_BEEF));
        send_beat(tick_beat());
        drain();
        write_display(1'b1);
        send_beat(load_beat(637, 477, 640, 478, 638, 480, 32'h00C0_FFEE));
        send_ticks(16);
    endtask

    // Coordinate extremes, reload mid-scan, point and line triangles, empty screen
    task automatic test_extreme_triangles();
        program_screen(2047, 2047, 1'b1);
        send_beat(load_beat(-2048, -2048, 2047, -2048, -2048, 2047, 32'hFFFF_FFFF));
        send_ticks(3);
        send_beat(load_beat(5, 5, 5, 5, 5, 5, 32'h0000_0000));
        send_ticks(2);
        send_beat(load_beat(0, 0, 3, 3, 1, 1, 32'hA5A5_5A5A));
        send_ticks(16);
        send_beat(load_beat(2047, 2047, 2047, 2047, 2047, 2047, 32'h1234_5678));
        send_ticks(1);
        send_beat(load_beat(2046, 2046, 2046, 2046, 2046, 2046, 32'h8765_4321));
        send_ticks(1);
        send_beat(load_beat(-2048, -2048, -2048, -2048, -2048, -2048, 32'h5555_AAAA));
        send_ticks(1);
        program_screen(0, 0, 1'b1);
        send_beat(load_beat(0, 0, 2, 0, 0, 2, 32'h0F0F_F0F0));
        send_ticks(9);
    endtask

    // Display off and pitch change between parts of one scan
    task automatic test_display_toggle_mid_scan();
        program_screen(64, 64, 1'b1);
        send_beat(load_beat(0, 0, 7, 0, 0, 7, 32'hCAFE_0001));
        send_ticks(20);
        program_screen(64, 64, 1'b0);
        send_ticks(20);
        // refused load must leave the running scan alone
        send_beat(load_beat(40, 40, 45, 41, 42, 47, 32'hBAD0_BAD0));
        program_screen(8, 64, 1'b1);
        send_ticks(25);
    endtask

    // Flat triangle in the far corner of the largest screen, scanned past its end
    task automatic test_wide_flat_scan();
        program_screen(2047, 2047, 1'b1);
        send_beat(load_beat(1960, 2047, 2047, 2047, 2000, 2045, 32'h7E57_7E57));
        send_ticks(88 * 3 + 2);
    endtask

    // Long output hold while ticks keep coming, so the input backs up
    task automatic test_output_backpressure();
        program_screen(32, 32, 1'b1);
        send_beat(load_beat(0, 0, 9, 0, 0, 9, 32'h0BAC_0BAC));
        hold_req <= ~hold_req;
        send_ticks(100);
    endtask

    // Random phases: mostly whole small-triangle scans, some noise and cut-short scans
    task automatic test_random_phases();
        int sent, pts, n, r, w, h;
        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: program_screen(0, 0, 1'b1);
                1: program_screen(2047, 2047, 1'b1);
                2: program_screen(1, 1, 1'b1);
                default: begin
                    w = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64)
                                                    : $urandom_range(0, 2047);
                    h = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 64)
                                                    : $urandom_range(0, 2047);
                    program_screen(w, h, $urandom_range(0, 5) != 0);
                end
            endcase
            sent = 0;
            while (sent < PHASE_BEATS) begin
                r = $urandom_range(0, 19);
                if (r < 15) begin
                    send_small_triangle(pts);
                    n = pts;
                    if ($urandom_range(0, 6) == 0)
                        n = $urandom_range(0, pts);
                    else if ($urandom_range(0, 9) == 0)
                        n = pts + $urandom_range(1, 3);
                    send_ticks(n);
                    sent += n + 1;
                end else if (r < 17) begin
                    send_beat(load_beat($urandom, $urandom, $urandom, $urandom,
                                        $urandom, $urandom, $urandom));
                    n = $urandom_range(0, 10);
                    send_ticks(n);
                    sent += n + 1;
                end else begin
                    send_beat(noise_beat());
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_extreme_triangles();
        test_display_toggle_mid_scan();
        test_wide_flat_scan();
        test_output_backpressure();
        test_random_phases();
        drain();
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("** triangle_fill_rasterizer_unit: PASSED **");
        end else begin
            $display("** triangle_fill_rasterizer_unit: FAILED **");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/tfr_pkg.sv
hdl/tfr_front.sv
hdl/tfr_back.sv
hdl/triangle_fill_rasterizer_unit.sv
bench/tb.sv
